// ===== rtl/slwc_pkg.sv =====
// Shared definitions for the sorted table with cursor: request codes, status codes,
// order modes and the command/status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package slwc_pkg;

  // Fixed field widths
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int MODE_W = 2;

  // Request codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_END  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Order modes (any other code orders ascending, new entry before equals)
  localparam logic [MODE_W-1:0] MODE_ASC_AFTER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DESC      = 2'd2;

  // Address counter update
  typedef enum logic [2:0] {
    A_HOLD,
    A_INC,
    A_DEC,
    A_ZERO,
    A_CURSOR,
    A_CURSOR_INC,
    A_FILL_DEC
  } addr_op_t;

  // Table write select
  typedef enum logic [1:0] {
    W_NONE,
    W_UP,     // entry at address moves one place up
    W_DOWN,   // entry at address moves one place down
    W_NEW     // new entry at insert point
  } wr_op_t;

  typedef enum logic [1:0] {
    F_HOLD,
    F_INC,
    F_DEC,
    F_CLEAR
  } fill_op_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_INC,
    C_ZERO,
    C_ADDR,
    C_IPOS_INC
  } cur_op_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    addr_op_t          addr_op;
    wr_op_t            wr_op;
    fill_op_t          fill_op;
    cur_op_t           cur_op;
    logic              mark_ipos;
    logic              take_read;
    logic              set_found;
    logic              set_status;
    logic [STAT_W-1:0] status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_fill;    // address counter equals fill count
    logic at_ipos;    // address counter equals insert point
    logic go_after;   // new key passes over the entry read
    logic tag_hit;    // entry read carries the requested tag
    logic full;       // table holds DEPTH entries
    logic cur_end;    // cursor past the last entry
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/slwc_dp.sv =====
// Datapath of the sorted table: entry memory with registered read, address counter,
// fill count, cursor, order mode register and result registers.
// Depends on slwc_pkg.
`default_nettype none

module slwc_dp #(
  parameter int DEPTH    = 32,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [slwc_pkg::MODE_W-1:0]   cfg_mode,
  input  logic [KEY_BITS-1:0]           in_key,
  input  logic [TAG_BITS-1:0]           in_tag,
  input  slwc_pkg::dp_cmd_t             cmd,
  output slwc_pkg::dp_stat_t            stat,
  output logic [KEY_BITS-1:0]           res_key,
  output logic [TAG_BITS-1:0]           res_tag,
  output logic [slwc_pkg::STAT_W-1:0]   res_status,
  output logic                          res_found,
  output logic [$clog2(DEPTH+1)-1:0]    res_pos,
  output logic [$clog2(DEPTH+1)-1:0]    fill
);

  import slwc_pkg::*;

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int AW     = $clog2(DEPTH);
  localparam int WORD_W = KEY_BITS + TAG_BITS;

  logic [WORD_W-1:0]   mem_r [DEPTH];
  logic [WORD_W-1:0]   rd_data_r;
  logic [CW-1:0]       addr_r, addr_nxt;
  logic [CW-1:0]       fill_r, cursor_r, ipos_r, pos_r;
  logic [MODE_W-1:0]   mode_r;
  logic [KEY_BITS-1:0] key_r, rkey_r;
  logic [TAG_BITS-1:0] tag_r, rtag_r;
  logic [STAT_W-1:0]   status_r;
  logic                found_r;
  logic                wr_en;
  logic [CW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic [KEY_BITS-1:0] old_key;
  logic [TAG_BITS-1:0] old_tag;
  logic                go_after;

  assign old_key = rd_data_r[WORD_W-1:TAG_BITS];
  assign old_tag = rd_data_r[TAG_BITS-1:0];

  // Address counter; the memory reads the next address so rd_data_r tracks addr_r
  always_comb begin
    case (cmd.addr_op)
      A_HOLD:       addr_nxt = addr_r;
      A_INC:        addr_nxt = addr_r + CW'(1);
      A_DEC:        addr_nxt = addr_r - CW'(1);
      A_ZERO:       addr_nxt = '0;
      A_CURSOR:     addr_nxt = cursor_r;
      A_CURSOR_INC: addr_nxt = cursor_r + CW'(1);
      A_FILL_DEC:   addr_nxt = fill_r - CW'(1);
      default:      addr_nxt = addr_r;
    endcase
  end

  // Write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ipos_r;
    wr_data = rd_data_r;
    case (cmd.wr_op)
      W_NONE: wr_en   = 1'b0;
      W_UP:   wr_addr = addr_r + CW'(1);
      W_DOWN: wr_addr = addr_r - CW'(1);
      W_NEW:  wr_data = {key_r, tag_r};
      default: wr_en  = 1'b0;
    endcase
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr[AW-1:0]] <= wr_data;
    end
    rd_data_r <= mem_r[addr_nxt[AW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      fill_r   <= '0;
      cursor_r <= '0;
      mode_r   <= '0;
    end else begin
      addr_r <= addr_nxt;
      if (cfg_we) begin
        mode_r <= cfg_mode;
      end
      case (cmd.fill_op)
        F_HOLD:  fill_r <= fill_r;
        F_INC:   fill_r <= fill_r + CW'(1);
        F_DEC:   fill_r <= fill_r - CW'(1);
        F_CLEAR: fill_r <= '0;
        default: fill_r <= fill_r;
      endcase
      case (cmd.cur_op)
        C_HOLD:     cursor_r <= cursor_r;
        C_INC:      cursor_r <= cursor_r + CW'(1);
        C_ZERO:     cursor_r <= '0;
        C_ADDR:     cursor_r <= addr_r;
        C_IPOS_INC: cursor_r <= ipos_r + CW'(1);
        default:    cursor_r <= cursor_r;
      endcase
    end
  end

  // Request operands and result registers; later statements override the clear on load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_key;
      tag_r    <= in_tag;
      status_r <= ST_OK;
      found_r  <= 1'b0;
      pos_r    <= '0;
      rkey_r   <= '0;
      rtag_r   <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.take_read) begin
      rkey_r <= old_key;
      rtag_r <= old_tag;
    end
    if (cmd.set_found) begin
      found_r <= 1'b1;
      pos_r   <= addr_r + CW'(1);
    end
    if (cmd.mark_ipos) begin
      ipos_r <= addr_r;
    end
  end

  // Order compare against the entry read
  always_comb begin
    case (mode_r)
      MODE_ASC_AFTER: go_after = key_r >= old_key;
      MODE_DESC:      go_after = key_r < old_key;
      default:        go_after = key_r > old_key;
    endcase
  end

  assign stat.go_after = go_after;
  assign stat.at_fill  = (addr_r == fill_r);
  assign stat.at_ipos  = (addr_r == ipos_r);
  assign stat.tag_hit  = (old_tag == tag_r);
  assign stat.full     = (fill_r == CW'(DEPTH));
  assign stat.cur_end  = (cursor_r >= fill_r);

  assign res_key    = rkey_r;
  assign res_tag    = rtag_r;
  assign res_status = status_r;
  assign res_found  = found_r;
  assign res_pos    = pos_r;
  assign fill       = fill_r;

endmodule

`default_nettype wire

// ===== rtl/slwc_ctrl.sv =====
// Controller of the sorted table: sequences scans and shifts over the entry memory
// and drives the datapath by command struct. Depends on slwc_pkg.
`default_nettype none

module slwc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [slwc_pkg::CMD_W-1:0]  in_cmd,
  output logic                        in_ready,
  input  logic                        out_free,
  output logic                        out_load,
  output slwc_pkg::dp_cmd_t           cmd,
  input  slwc_pkg::dp_stat_t          stat
);

  import slwc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_INS,
    S_SHIFT_UP,
    S_INS_WR,
    S_FIND,
    S_SHIFT_DN,
    S_GET,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      // Take a request and start its work
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DONE;
          case (in_cmd)
            CMD_INSERT: begin
              if (stat.full) begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_FULL;
              end else begin
                cmd.addr_op = A_ZERO;
                state_nxt   = S_SCAN_INS;
              end
            end
            CMD_GET: begin
              if (stat.cur_end) begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_END;
              end else begin
                cmd.addr_op = A_CURSOR;
                state_nxt   = S_GET;
              end
            end
            CMD_NEXT: begin
              if (stat.cur_end) begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_END;
              end else begin
                cmd.cur_op = C_INC;
              end
            end
            CMD_REMOVE: begin
              if (stat.cur_end) begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_END;
              end else begin
                cmd.addr_op = A_CURSOR_INC;
                state_nxt   = S_SHIFT_DN;
              end
            end
            CMD_HEAD: begin
              cmd.cur_op = C_ZERO;
            end
            CMD_FIND: begin
              cmd.addr_op = A_ZERO;
              state_nxt   = S_FIND;
            end
            CMD_CLEAR: begin
              cmd.fill_op = F_CLEAR;
              cmd.cur_op  = C_ZERO;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // Walk up to the first entry the new key does not pass
      S_SCAN_INS: begin
        if (stat.at_fill || !stat.go_after) begin
          cmd.mark_ipos = 1'b1;
          if (stat.at_fill) begin
            state_nxt = S_INS_WR;
          end else begin
            cmd.addr_op = A_FILL_DEC;
            state_nxt   = S_SHIFT_UP;
          end
        end else begin
          cmd.addr_op = A_INC;
        end
      end
      // Move entries up one place, from the top down to the insert point
      S_SHIFT_UP: begin
        cmd.wr_op = W_UP;
        if (stat.at_ipos) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.addr_op = A_DEC;
        end
      end
      S_INS_WR: begin
        cmd.wr_op   = W_NEW;
        cmd.fill_op = F_INC;
        cmd.cur_op  = C_IPOS_INC;
        state_nxt   = S_DONE;
      end
      // Tag search
      S_FIND: begin
        if (stat.at_fill) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_END;
          cmd.cur_op     = C_ADDR;
          state_nxt      = S_DONE;
        end else if (stat.tag_hit) begin
          cmd.take_read = 1'b1;
          cmd.set_found = 1'b1;
          cmd.cur_op    = C_ADDR;
          state_nxt     = S_DONE;
        end else begin
          cmd.addr_op = A_INC;
        end
      end
      // Move entries above the cursor down one place
      S_SHIFT_DN: begin
        if (stat.at_fill) begin
          cmd.fill_op = F_DEC;
          state_nxt   = S_DONE;
        end else begin
          cmd.wr_op   = W_DOWN;
          cmd.addr_op = A_INC;
        end
      end
      S_GET: begin
        cmd.take_read = 1'b1;
        state_nxt     = S_DONE;
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_with_cursor.sv =====
// Sorted table with cursor, one request at a time. Insert and find run a memory scan,
// one entry per cycle, then for insert a shift pass; remove runs a shift pass.
// Synchronous active-low reset clears fill count, cursor, order mode, controller
// and output valid; the entry memory is not cleared (only filled entries are read).
`default_nettype none

module sorted_list_with_cursor #(
  parameter int DEPTH    = 32,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  // Request channel
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // tdata: entry_key, entry_tag (lowest bits first), zero padded to bytes
  input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0]         in_tdata,
  // tuser: command
  input  logic [slwc_pkg::CMD_W-1:0]                     in_tuser,
  // Result channel
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // tdata: read_key, read_tag, status, found, position, is_empty, entry_count
  output logic [((KEY_BITS+TAG_BITS+16+7)/8)*8-1:0]      out_tdata,
  // Order mode write channel
  input  logic                                           cfg_valid,
  output logic                                           cfg_ready,
  input  logic [slwc_pkg::MODE_W-1:0]                    cfg_data
);

  import slwc_pkg::*;

  localparam int CW       = $clog2(DEPTH + 1);
  localparam int OUT_W    = KEY_BITS + TAG_BITS + STAT_W + 1 + POS_W + 1 + POS_W;
  localparam int OUT_PD_W = ((KEY_BITS + TAG_BITS + 16 + 7) / 8) * 8;

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic                out_free, out_load;
  logic [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0] res_tag;
  logic [STAT_W-1:0]   res_status;
  logic                res_found;
  logic [CW-1:0]       res_pos, fill;
  logic [OUT_W-1:0]    res_word;
  logic                out_tvalid_r;
  logic [OUT_PD_W-1:0] out_tdata_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  slwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_ready (in_tready),
    .out_free (out_free),
    .out_load (out_load),
    .cmd      (cmd),
    .stat     (stat)
  );

  slwc_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_mode   (cfg_data),
    .in_key     (in_tdata[KEY_BITS-1:0]),
    .in_tag     (in_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS]),
    .cmd        (cmd),
    .stat       (stat),
    .res_key    (res_key),
    .res_tag    (res_tag),
    .res_status (res_status),
    .res_found  (res_found),
    .res_pos    (res_pos),
    .fill       (fill)
  );

  // Pack result fields, lowest first
  assign res_word = {POS_W'(fill), (fill == '0), POS_W'(res_pos), res_found,
                     res_status, res_tag, res_key};

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= OUT_PD_W'(res_word);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // A result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten while pending");

  // Every request keeps the block busy, so no request is taken in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken twice in a row");

  // A find hit lies inside the table
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_found) |-> (res_pos != '0 && res_pos <= fill))
    else $error("find position outside the table");

  // Fill count never exceeds the capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (fill <= CW'(DEPTH)))
    else $error("fill count above capacity");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for sorted_list_with_cursor: random and directed requests checked against a
// shadow copy of the sorted table, cursor and order mode kept in the bench.
// Depends on slwc_pkg and the sorted_list_with_cursor RTL.
`timescale 1ns / 1ps

module tb;
  import slwc_pkg::*;

  localparam int LIST_DEPTH   = 32;
  localparam int KEY_W        = 32;
  localparam int TAG_W        = 16;
  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  // Codes that the package leaves unnamed
  localparam logic [CMD_W-1:0]  CMD_UNUSED      = 3'd7;
  localparam logic [MODE_W-1:0] MODE_ASC_BEFORE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } list_entry_t;

  // Matches out_tdata: read_key in the lowest bits, entry_count on top
  typedef struct packed {
    logic [POS_W-1:0]  entry_count;
    logic              is_empty;
    logic [POS_W-1:0]  position;
    logic              found;
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  read_tag;
    logic [KEY_W-1:0]  read_key;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [47:0] in_tdata;   // entry_key [31:0], entry_tag [47:32]
  logic [CMD_W-1:0] in_tuser;   // command
  logic out_tvalid;
  logic out_tready;
  logic [63:0] out_tdata;  // read_key, read_tag, status, found, position, is_empty, entry_count
  logic cfg_valid;
  logic cfg_ready;
  logic [MODE_W-1:0] cfg_data;

  // Shadow state
  list_entry_t shadow_list[$];
  int shadow_cursor;
  logic [MODE_W-1:0] shadow_mode;
  result_t pending_results[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  logic no_idle;
  logic long_hold_req;

  sorted_list_with_cursor #(
    .DEPTH(LIST_DEPTH),
    .KEY_BITS(KEY_W),
    .TAG_BITS(TAG_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // True when a new key is placed past an entry holding old_key
  function automatic logic passes_over(logic [KEY_W-1:0] new_key, logic [KEY_W-1:0] old_key);
    if (shadow_mode == MODE_ASC_AFTER) return new_key >= old_key;
    if (shadow_mode == MODE_DESC) return new_key < old_key;
    return new_key > old_key;
  endfunction

  // Applies one request to the shadow table and returns its expected result
  function automatic result_t apply_to_shadow(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                              logic [TAG_W-1:0] tag);
    result_t r;
    list_entry_t e;
    int i;
    r = '0;
    i = 0;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_list.size() >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          while (i < shadow_list.size() && passes_over(key, shadow_list[i].key)) i++;
          e.key = key;
          e.tag = tag;
          shadow_list.insert(i, e);
          shadow_cursor = i + 1;
        end
      end
      CMD_GET: begin
        if (shadow_cursor >= shadow_list.size()) begin
          r.status = ST_END;
        end else begin
          r.read_key = shadow_list[shadow_cursor].key;
          r.read_tag = shadow_list[shadow_cursor].tag;
        end
      end
      CMD_NEXT: begin
        if (shadow_cursor >= shadow_list.size()) r.status = ST_END;
        else shadow_cursor++;
      end
      CMD_REMOVE: begin
        if (shadow_cursor >= shadow_list.size()) r.status = ST_END;
        else shadow_list.delete(shadow_cursor);
      end
      CMD_HEAD: shadow_cursor = 0;
      CMD_FIND: begin
        while (i < shadow_list.size() && shadow_list[i].tag != tag) i++;
        shadow_cursor = i;
        if (i < shadow_list.size()) begin
          r.found    = 1'b1;
          r.position = POS_W'(i + 1);
          r.read_key = shadow_list[i].key;
          r.read_tag = shadow_list[i].tag;
        end else begin
          r.status = ST_END;
        end
      end
      CMD_CLEAR: begin
        shadow_list.delete();
        shadow_cursor = 0;
      end
      default: ;
    endcase
    r.is_empty    = (shadow_list.size() == 0);
    r.entry_count = POS_W'(shadow_list.size());
    return r;
  endfunction

  function automatic void check_field(string name, logic [KEY_W-1:0] exp_v,
                                      logic [KEY_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t exp_r;
    result_t got_r;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got_r = out_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("read_key", exp_r.read_key, got_r.read_key);
        check_field("read_tag", KEY_W'(exp_r.read_tag), KEY_W'(got_r.read_tag));
        check_field("status", KEY_W'(exp_r.status), KEY_W'(got_r.status));
        check_field("found", KEY_W'(exp_r.found), KEY_W'(got_r.found));
        check_field("position", KEY_W'(exp_r.position), KEY_W'(got_r.position));
        check_field("is_empty", KEY_W'(exp_r.is_empty), KEY_W'(got_r.is_empty));
        check_field("entry_count", KEY_W'(exp_r.entry_count), KEY_W'(got_r.entry_count));
      end
    end
  end

  // Result side: random stall per result, one long hold-off on request
  initial begin : result_drain
    int wait_cycles;
    out_tready <= 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid === 1'b1 && out_tready === 1'b1));
    end
  end

  // Sends one request; the expectation is queued at the accepting edge
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [TAG_W-1:0] tag);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {tag, key};
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_results.push_back(apply_to_shadow(cmd, key, tag));
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_order_mode(input logic [MODE_W-1:0] mode);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    shadow_mode = mode;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small keys so equal keys are common; some extremes and full range
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return KEY_W'($urandom_range(0, 15));
    if (roll < 65) return '0;
    if (roll < 75) return '1;
    return $urandom;
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 99) < 60) return TAG_W'($urandom_range(0, 7));
    return TAG_W'($urandom);
  endfunction

  // Command mix tuned to keep the table between empty and full
  function automatic logic [CMD_W-1:0] pick_command();
    int roll;
    int fill;
    roll = $urandom_range(0, 99);
    fill = shadow_list.size();
    if (fill < 3 && roll < 60) return CMD_INSERT;
    if (fill > 28 && roll < 25) return CMD_REMOVE;
    if (fill > 28 && roll < 32) return CMD_HEAD;
    if (roll < 32) return CMD_INSERT;
    if (roll < 46) return CMD_GET;
    if (roll < 60) return CMD_NEXT;
    if (roll < 73) return CMD_REMOVE;
    if (roll < 81) return CMD_HEAD;
    if (roll < 94) return CMD_FIND;
    if (roll < 96) return CMD_CLEAR;
    return CMD_UNUSED;
  endfunction

  task automatic send_random_request();
    logic [CMD_W-1:0] cmd;
    logic [TAG_W-1:0] tag;
    cmd = pick_command();
    tag = pick_tag();
    // Find mostly looks for a tag that is held
    if (cmd == CMD_FIND && shadow_list.size() > 0 && $urandom_range(0, 99) < 70)
      tag = shadow_list[$urandom_range(0, shadow_list.size() - 1)].tag;
    send_request(cmd, pick_key(), tag);
  endtask

  // Empty table, end-of-list cases, equal keys, find hit and miss, clear
  task automatic test_directed();
    send_request(CMD_GET, '0, '0);
    send_request(CMD_NEXT, '0, '0);
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_FIND, '0, '0);
    send_request(CMD_UNUSED, '1, '1);
    send_request(CMD_HEAD, '0, '0);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, '1, '1);
    send_request(CMD_INSERT, 32'd5, 16'd1);
    send_request(CMD_INSERT, 32'd5, 16'd2);
    send_request(CMD_HEAD, '0, '0);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_NEXT, '0, '0);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_FIND, '0, 16'd2);
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_FIND, '0, '1);
    send_request(CMD_NEXT, '0, '0);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_FIND, '0, 16'h1234);
    send_request(CMD_UNUSED, 32'h5a5a_a5a5, 16'h3c3c);
    send_request(CMD_CLEAR, '0, '0);
    send_request(CMD_GET, '0, '0);
  endtask

  // Equal and unequal keys under each order mode, then a walk from the head
  task automatic test_order_modes();
    logic [MODE_W-1:0] modes[3] = '{MODE_ASC_AFTER, MODE_DESC, MODE_UNUSED};
    foreach (modes[m]) begin
      write_order_mode(modes[m]);
      send_request(CMD_CLEAR, '0, '0);
      send_request(CMD_INSERT, 32'd5, 16'd10);
      send_request(CMD_INSERT, 32'd3, 16'd11);
      send_request(CMD_INSERT, 32'd5, 16'd12);
      send_request(CMD_INSERT, 32'd7, 16'd13);
      send_request(CMD_HEAD, '0, '0);
      repeat (4) begin
        send_request(CMD_GET, '0, '0);
        send_request(CMD_NEXT, '0, '0);
      end
    end
  endtask

  // Fill to capacity, refused insert, then make room again
  task automatic test_full_table();
    write_order_mode(MODE_DESC);
    send_request(CMD_CLEAR, '0, '0);
    repeat (LIST_DEPTH) send_request(CMD_INSERT, pick_key(), pick_tag());
    send_request(CMD_INSERT, '1, '1);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_HEAD, '0, '0);
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_CLEAR, '0, '0);
  endtask

  // Long receiver hold-off while requests keep coming, then a full pause
  task automatic test_backpressure();
    write_order_mode(MODE_ASC_BEFORE);
    long_hold_req = 1'b1;
    no_idle = 1'b1;
    repeat (40) send_random_request();
    no_idle = 1'b0;
    wait_all_results();
    repeat (20) send_random_request();
  endtask

  task automatic test_random_phase(input logic [MODE_W-1:0] mode, input int count,
                                   input logic gap_free);
    write_order_mode(mode);
    no_idle = gap_free;
    repeat (count) send_random_request();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= CMD_HEAD;
    cfg_valid     <= 1'b0;
    cfg_data      <= MODE_ASC_BEFORE;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    shadow_cursor = 0;
    shadow_mode   = MODE_ASC_BEFORE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_order_modes();
    test_full_table();
    test_backpressure();
    test_random_phase(MODE_ASC_AFTER, 130, 1'b0);
    test_random_phase(MODE_DESC, 130, 1'b0);
    test_random_phase(MODE_UNUSED, 130, 1'b1);
    test_random_phase(MODE_ASC_BEFORE, 130, 1'b0);

    wait_all_results();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sorted_list_with_cursor.f =====
rtl/slwc_pkg.sv
rtl/slwc_dp.sv
rtl/slwc_ctrl.sv
rtl/sorted_list_with_cursor.sv
bench/tb.sv
